FILE: rtl/block_difference_compare_macros.svh
// assertion macros shared by the checker
`ifndef BLOCK_DIFFERENCE_COMPARE_MACROS_SVH
`define BLOCK_DIFFERENCE_COMPARE_MACROS_SVH

// checked only outside reset
`define BDC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bdc assertion failed");

// checked at every edge, reset included
`define BDC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bdc assertion failed");

`endif

FILE: rtl/bdc_pkg.sv
package bdc_pkg;

  localparam int BYTE_W            = 8;
  localparam int LEN_REG_W         = 17;
  localparam int CFG_INDEX_W       = 2;
  localparam int CFG_DATA_W        = 17;
  localparam int VERDICT_W         = 2;
  localparam int MAX_BLOCK_DEFAULT = 65536;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [LEN_REG_W-1:0] LENGTH_RESET = 17'd4096;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_EQUAL     = 2'd0,
    VERDICT_NOT_EQUAL = 2'd1,
    VERDICT_PADDING   = 2'd2,
    VERDICT_LEVEL     = 2'd3
  } verdict_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BLOCK_LENGTH = 2'd0,
    REG_LEVEL_MODE   = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_DIVIDE,
    BACK_HOLD
  } back_state_t;

endpackage

FILE: rtl/block_difference_compare.sv
// Block-wise comparison of two byte streams, one byte pair per word.
// Input queue side: push/full carries byte_a, byte_b, a_ended, b_ended; an
// ended stream's byte counts as zero. Result queue side: empty/pop carries
// verdict and level, one word at the end of each block.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 block_length,
// 1 level_mode) and cfg_data; cfg_ready is always high. Write only while idle.
// Timing: input words are taken one per cycle while the two-entry job queue
// between front and back has room. A block end writes a job into the queue;
// the back end takes it and registers the result directly in equality mode,
// or after a one-bit-per-cycle divider in level mode. The back end clears a
// shown result in the cycle after pop and takes no new job while one is shown.
// When pop stays low the result holds, the job queue fills and full rises.
// Reset (rst, synchronous) empties the queues, clears block state and loads
// block_length 4096, level_mode 0.
module block_difference_compare #(
  parameter int MAX_BLOCK = bdc_pkg::MAX_BLOCK_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bdc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic [bdc_pkg::BYTE_W-1:0]      byte_a,
  input  logic [bdc_pkg::BYTE_W-1:0]      byte_b,
  input  logic                            a_ended,
  input  logic                            b_ended,
  output logic                            empty,
  input  logic                            pop,
  output logic [bdc_pkg::VERDICT_W-1:0]   verdict,
  output logic [bdc_pkg::BYTE_W-1:0]      level
);

  localparam int LW = $clog2(MAX_BLOCK + 1);
  localparam int SW = $clog2(64'(MAX_BLOCK) * 64'd255 + 64'd1);
  localparam int JW = bdc_pkg::VERDICT_W + SW + LW;

  logic          job_push;
  logic          job_full;
  logic [JW-1:0] job_wdata;
  logic          job_pop;
  logic          job_empty;
  logic [JW-1:0] job_rdata;

  bdc_front #(
    .MAX_BLOCK (MAX_BLOCK),
    .LW        (LW),
    .SW        (SW),
    .JW        (JW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .byte_a    (byte_a),
    .byte_b    (byte_b),
    .a_ended   (a_ended),
    .b_ended   (b_ended),
    .job_push  (job_push),
    .job_full  (job_full),
    .job_data  (job_wdata)
  );

  bdc_queue #(
    .WIDTH (JW),
    .DEPTH (bdc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .full  (job_full),
    .wdata (job_wdata),
    .pop   (job_pop),
    .empty (job_empty),
    .rdata (job_rdata)
  );

  bdc_back #(
    .MAX_BLOCK (MAX_BLOCK),
    .LW        (LW),
    .SW        (SW),
    .JW        (JW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_pop   (job_pop),
    .job_empty (job_empty),
    .job_data  (job_rdata),
    .empty     (empty),
    .pop       (pop),
    .verdict   (verdict),
    .level     (level)
  );

endmodule

FILE: rtl/bdc_front.sv
module bdc_front #(
  parameter int MAX_BLOCK = bdc_pkg::MAX_BLOCK_DEFAULT,
  parameter int LW = $clog2(MAX_BLOCK + 1),
  parameter int SW = $clog2(64'(MAX_BLOCK) * 64'd255 + 64'd1),
  parameter int JW = bdc_pkg::VERDICT_W + SW + LW
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bdc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               push,
  output logic                               full,
  input  logic [bdc_pkg::BYTE_W-1:0]         byte_a,
  input  logic [bdc_pkg::BYTE_W-1:0]         byte_b,
  input  logic                               a_ended,
  input  logic                               b_ended,
  output logic                               job_push,
  input  logic                               job_full,
  output logic [JW-1:0]                      job_data
);

  localparam int CW = (LW > bdc_pkg::LEN_REG_W) ? LW : bdc_pkg::LEN_REG_W;

  logic [bdc_pkg::LEN_REG_W-1:0] block_length;
  logic                          level_mode;
  logic [LW-1:0]                 count;
  logic [SW-1:0]                 sum;
  logic                          mismatch_seen;
  logic                          end_in_block;
  logic                          streams_done;

  logic [CW-1:0]                 len_wide;
  logic [LW-1:0]                 len_eff;
  logic [bdc_pkg::BYTE_W-1:0]    a;
  logic [bdc_pkg::BYTE_W-1:0]    b;
  logic [bdc_pkg::BYTE_W-1:0]    diff;
  logic [LW-1:0]                 count_inc;
  logic [SW-1:0]                 sum_new;
  logic                          mismatch_new;
  logic                          end_new;
  logic                          block_end;
  logic                          accept;
  bdc_pkg::verdict_t             verdict_new;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= bdc_pkg::LENGTH_RESET;
      level_mode   <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == bdc_pkg::REG_BLOCK_LENGTH) begin
        block_length <= cfg_data[bdc_pkg::LEN_REG_W-1:0];
      end else if (cfg_index == bdc_pkg::REG_LEVEL_MODE) begin
        level_mode <= cfg_data[0];
      end
    end
  end

  // zero acts as one, oversized saturates
  always_comb begin
    len_wide = CW'(block_length);
    if (block_length == '0) begin
      len_eff = LW'(1);
    end else if (len_wide > CW'(MAX_BLOCK)) begin
      len_eff = LW'(MAX_BLOCK);
    end else begin
      len_eff = LW'(len_wide);
    end
  end

  always_comb begin
    a            = a_ended ? '0 : byte_a;
    b            = b_ended ? '0 : byte_b;
    diff         = (a > b) ? (a - b) : (b - a);
    count_inc    = count + LW'(1);
    sum_new      = sum + SW'(diff);
    mismatch_new = mismatch_seen | (a != b);
    end_new      = end_in_block | a_ended | b_ended;
    block_end    = count_inc >= len_eff;
    accept       = push & ~job_full;
    if (streams_done) begin
      verdict_new = bdc_pkg::VERDICT_PADDING;
    end else if (level_mode) begin
      verdict_new = bdc_pkg::VERDICT_LEVEL;
    end else if (mismatch_new) begin
      verdict_new = bdc_pkg::VERDICT_NOT_EQUAL;
    end else begin
      verdict_new = bdc_pkg::VERDICT_EQUAL;
    end
  end

  assign full     = job_full;
  assign job_push = accept & block_end;
  assign job_data = {verdict_new, sum_new, len_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      sum           <= '0;
      mismatch_seen <= 1'b0;
      end_in_block  <= 1'b0;
      streams_done  <= 1'b0;
    end else if (accept) begin
      if (block_end) begin
        count         <= '0;
        sum           <= '0;
        mismatch_seen <= 1'b0;
        end_in_block  <= 1'b0;
        streams_done  <= streams_done | end_new;
      end else begin
        count         <= count_inc;
        sum           <= sum_new;
        mismatch_seen <= mismatch_new;
        end_in_block  <= end_new;
      end
    end
  end

endmodule

FILE: rtl/bdc_queue.sv
module bdc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bdc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNTW'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

FILE: rtl/bdc_back.sv
module bdc_back #(
  parameter int MAX_BLOCK = bdc_pkg::MAX_BLOCK_DEFAULT,
  parameter int LW = $clog2(MAX_BLOCK + 1),
  parameter int SW = $clog2(64'(MAX_BLOCK) * 64'd255 + 64'd1),
  parameter int JW = bdc_pkg::VERDICT_W + SW + LW
) (
  input  logic                           clk,
  input  logic                           rst,
  output logic                           job_pop,
  input  logic                           job_empty,
  input  logic [JW-1:0]                  job_data,
  output logic                           empty,
  input  logic                           pop,
  output logic [bdc_pkg::VERDICT_W-1:0]  verdict,
  output logic [bdc_pkg::BYTE_W-1:0]     level
);

  localparam int SCW = $clog2(SW);

  bdc_pkg::back_state_t state;
  bdc_pkg::back_state_t state_next;

  bdc_pkg::verdict_t    job_verdict;
  logic [SW-1:0]        job_sum;
  logic [LW-1:0]        job_len;

  logic [SW-1:0]        quo;
  logic [LW-1:0]        rem;
  logic [LW-1:0]        divisor;
  logic [SCW-1:0]       step;
  bdc_pkg::verdict_t    res_verdict;
  logic [bdc_pkg::BYTE_W-1:0] res_level;

  logic [LW:0]          trial;
  logic                 ge;
  logic [LW-1:0]        rem_next;
  logic [SW-1:0]        quo_next;

  logic                 load_div;
  logic                 load_direct;
  logic                 div_step;
  logic                 div_last;

  assign job_verdict = bdc_pkg::verdict_t'(job_data[JW-1 -: bdc_pkg::VERDICT_W]);
  assign job_sum     = job_data[LW +: SW];
  assign job_len     = job_data[LW-1:0];

  // one restoring division step per cycle
  always_comb begin
    trial    = {rem, quo[SW-1]};
    ge       = trial >= {1'b0, divisor};
    rem_next = ge ? LW'(trial - {1'b0, divisor}) : LW'(trial);
    quo_next = {quo[SW-2:0], ge};
  end

  always_comb begin
    state_next = state;
    case (state)
      bdc_pkg::BACK_IDLE: begin
        if (!job_empty) begin
          state_next = (job_verdict == bdc_pkg::VERDICT_LEVEL) ?
                       bdc_pkg::BACK_DIVIDE : bdc_pkg::BACK_HOLD;
        end
      end
      bdc_pkg::BACK_DIVIDE: begin
        if (step == '0) begin
          state_next = bdc_pkg::BACK_HOLD;
        end
      end
      bdc_pkg::BACK_HOLD: begin
        if (pop) begin
          state_next = bdc_pkg::BACK_IDLE;
        end
      end
      default: state_next = bdc_pkg::BACK_IDLE;
    endcase
  end

  always_comb begin
    job_pop     = 1'b0;
    load_div    = 1'b0;
    load_direct = 1'b0;
    div_step    = 1'b0;
    div_last    = 1'b0;
    empty       = 1'b1;
    case (state)
      bdc_pkg::BACK_IDLE: begin
        job_pop     = ~job_empty;
        load_div    = ~job_empty & (job_verdict == bdc_pkg::VERDICT_LEVEL);
        load_direct = ~job_empty & (job_verdict != bdc_pkg::VERDICT_LEVEL);
      end
      bdc_pkg::BACK_DIVIDE: begin
        div_step = 1'b1;
        div_last = step == '0;
      end
      bdc_pkg::BACK_HOLD: begin
        empty = 1'b0;
      end
      default: begin
        empty = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdc_pkg::BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_div) begin
      quo     <= job_sum;
      rem     <= '0;
      divisor <= job_len;
      step    <= SCW'(SW - 1);
    end
    if (div_step) begin
      quo  <= quo_next;
      rem  <= rem_next;
      step <= step - SCW'(1);
    end
    if (load_direct) begin
      res_verdict <= job_verdict;
      res_level   <= '0;
    end
    if (div_last) begin
      res_verdict <= bdc_pkg::VERDICT_LEVEL;
      res_level   <= quo_next[bdc_pkg::BYTE_W-1:0];
    end
  end

  assign verdict = res_verdict;
  assign level   = res_level;

endmodule

FILE: rtl/bdc_checker.sv
`include "block_difference_compare_macros.svh"

module bdc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          empty,
  input logic                          pop,
  input logic [bdc_pkg::VERDICT_W-1:0] verdict,
  input logic [bdc_pkg::BYTE_W-1:0]    level
);

  // nothing to deliver right after reset
  `BDC_ASSERT_ALWAYS(a_reset_empty, rst |=> empty)

  // a stalled result holds
  `BDC_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(verdict) && $stable(level))

  // level is zero unless a level verdict
  `BDC_ASSERT(a_level_zero, !empty && verdict != bdc_pkg::VERDICT_LEVEL |-> level == '0)

  // back end returns to idle after each taken result
  `BDC_ASSERT(a_pop_clears, !empty && pop |=> empty)

endmodule

bind block_difference_compare bdc_checker u_checker (.*);
